>>> rtl/slpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slpe_pkg;

   // width of the duty level
   localparam int DUTY_BITS = 10;

   // field widths
   localparam int MODE_BITS  = 3;
   localparam int COUNT_BITS = 12;
   localparam int HOLD_BITS  = COUNT_BITS + 1;
   localparam int BLINK_BITS = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   // pattern constants
   localparam logic [DUTY_BITS-1:0] FULL_LEVEL = DUTY_BITS'(255);
   localparam logic [HOLD_BITS-1:0] GAP_MS     = HOLD_BITS'(2);
   localparam logic [HOLD_BITS-1:0] SLOW_MS    = HOLD_BITS'(800);
   localparam logic [HOLD_BITS-1:0] FAST_MS    = HOLD_BITS'(300);
   localparam logic [HOLD_BITS-1:0] BLINK_MS   = HOLD_BITS'(100);
   localparam logic [HOLD_BITS-1:0] REST_MS    = HOLD_BITS'(1000);
   localparam logic [BLINK_BITS-1:0] BLINK_TOTAL = BLINK_BITS'(4);

   // register reset values
   localparam logic [7:0]  MAX_BRIGHTNESS_RESET = 8'd50;
   localparam logic [7:0]  STEP_DELAY_RESET     = 8'd26;
   localparam logic [11:0] PEAK_PAUSE_RESET     = 12'd656;

   // request kinds
   localparam logic REQ_TICK     = 1'b0;
   localparam logic REQ_SET_MODE = 1'b1;

   // device modes
   localparam logic [MODE_BITS-1:0] MODE_SETUP      = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_CONNECTING = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_CONNECTED  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_NORMAL     = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_ERROR      = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_BRIGHTNESS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_DELAY     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PEAK_PAUSE     = 2'd2;

   // pattern phase, one-hot
   typedef enum logic [6:0] {
      PH_GAP   = 7'b0000001,
      PH_ON    = 7'b0000010,
      PH_OFF   = 7'b0000100,
      PH_UP    = 7'b0001000,
      PH_PAUSE = 7'b0010000,
      PH_DOWN  = 7'b0100000,
      PH_REST  = 7'b1000000
   } phase_type;

   // running pattern
   typedef enum logic [2:0] {
      PK_NONE    = 3'd0,
      PK_SLOW    = 3'd1,
      PK_FAST    = 3'd2,
      PK_BLINK   = 3'd3,
      PK_BREATHE = 3'd4
   } pattern_type;

   typedef struct packed {
      logic                 req_type;
      logic [MODE_BITS-1:0] mode_value;
      logic                 charging;
   } req_payload_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic [MODE_BITS-1:0] mode_now;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/status_led_pattern_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Status LED pattern engine. Each request transaction is either a one
// millisecond tick or a mode write; each one yields exactly one response
// carrying the LED duty level and the stored mode after that transaction.
// A transaction is accepted every cycle and its response appears in the
// response register on the next cycle; the only stall is a response that
// still waits for rsp_ready, which holds req_ready low. The csr port is
// always ready and sets the breathing peak, ramp step time and peak pause.
module status_led_pattern_engine_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire slpe_pkg::req_payload_type          req_payload,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      slpe_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [slpe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [slpe_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import slpe_pkg::*;

   logic [7:0]            max_brightness_ff;
   logic [7:0]            step_delay_ff;
   logic [11:0]           peak_pause_ff;

   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   phase_type             phase_ff, phase_in;
   pattern_type           kind_ff, kind_in;
   logic [DUTY_BITS-1:0]  duty_ff, duty_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [BLINK_BITS-1:0] blink_ff, blink_in;

   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff, rsp_in;

   logic                  req_fire;
   logic [HOLD_BITS-1:0]  hold_ms;
   logic [HOLD_BITS-1:0]  count_sum;
   logic [BLINK_BITS-1:0] blink_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_brightness_ff <= MAX_BRIGHTNESS_RESET;
         step_delay_ff     <= STEP_DELAY_RESET;
         peak_pause_ff     <= PEAK_PAUSE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_BRIGHTNESS: max_brightness_ff <= csr_data[7:0];
            CSR_STEP_DELAY:     step_delay_ff     <= csr_data[7:0];
            CSR_PEAK_PAUSE:     peak_pause_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // length of the current phase, zero delays count as one
   always_comb begin
      case (phase_ff)
         PH_GAP: hold_ms = GAP_MS;
         PH_ON, PH_OFF: begin
            if (kind_ff == PK_SLOW)      hold_ms = SLOW_MS;
            else if (kind_ff == PK_FAST) hold_ms = FAST_MS;
            else                         hold_ms = BLINK_MS;
         end
         PH_UP, PH_DOWN: hold_ms = (step_delay_ff == 8'd0) ? HOLD_BITS'(1)
                                                           : HOLD_BITS'(step_delay_ff);
         PH_PAUSE: hold_ms = (peak_pause_ff == 12'd0) ? HOLD_BITS'(1)
                                                      : HOLD_BITS'(peak_pause_ff);
         default: hold_ms = REST_MS;
      endcase
   end

   assign count_sum  = HOLD_BITS'(count_ff) + HOLD_BITS'(1);
   assign blink_next = blink_ff + BLINK_BITS'(1);

   // next pattern state for one transaction
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      duty_in  = duty_ff;
      count_in = count_ff;
      blink_in = blink_ff;
      if (req_payload.req_type == REQ_SET_MODE) begin
         mode_in = req_payload.mode_value;
      end else if (count_sum < hold_ms) begin
         count_in = count_sum[COUNT_BITS-1:0];
      end else begin
         count_in = '0;
         case (phase_ff)
            PH_GAP: begin
               // pattern start, mode checked only here
               if (mode_ff == MODE_NORMAL && req_payload.charging) begin
                  kind_in  = PK_BREATHE;
                  phase_in = PH_UP;
                  duty_in  = '0;
               end else if (mode_ff inside {MODE_SETUP, MODE_CONNECTING,
                                            MODE_CONNECTED}) begin
                  if (mode_ff == MODE_SETUP)           kind_in = PK_SLOW;
                  else if (mode_ff == MODE_CONNECTING) kind_in = PK_FAST;
                  else                                 kind_in = PK_BLINK;
                  blink_in = '0;
                  phase_in = PH_ON;
                  duty_in  = FULL_LEVEL;
               end else begin
                  kind_in  = PK_NONE;
                  phase_in = PH_GAP;
               end
            end
            PH_ON: begin
               phase_in = PH_OFF;
               duty_in  = '0;
            end
            PH_OFF: begin
               if (kind_ff == PK_BLINK) begin
                  blink_in = blink_next;
                  if (blink_next >= BLINK_TOTAL) begin
                     mode_in  = MODE_NORMAL;
                     phase_in = PH_GAP;
                  end else begin
                     phase_in = PH_ON;
                     duty_in  = FULL_LEVEL;
                  end
               end else begin
                  phase_in = PH_GAP;
               end
            end
            PH_UP: begin
               // rising ramp follows the live peak
               if (duty_ff < DUTY_BITS'(max_brightness_ff)) begin
                  duty_in = duty_ff + DUTY_BITS'(1);
               end else begin
                  phase_in = PH_PAUSE;
               end
            end
            PH_PAUSE: begin
               phase_in = PH_DOWN;
               duty_in  = DUTY_BITS'(max_brightness_ff);
            end
            PH_DOWN: begin
               if (duty_ff != '0) begin
                  duty_in = duty_ff - DUTY_BITS'(1);
               end else begin
                  phase_in = PH_REST;
               end
            end
            default: begin
               phase_in = PH_GAP;
            end
         endcase
      end
      rsp_in.duty     = duty_in;
      rsp_in.mode_now = mode_in;
   end

   // pattern state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SETUP;
         phase_ff <= PH_GAP;
         kind_ff  <= PK_NONE;
         duty_ff  <= '0;
         count_ff <= '0;
         blink_ff <= '0;
      end else if (req_fire) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         duty_ff  <= duty_in;
         count_ff <= count_in;
         blink_ff <= blink_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_fire || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/slpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slpe_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire slpe_pkg::req_payload_type req_payload,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire slpe_pkg::rsp_payload_type rsp_payload
);
   import slpe_pkg::*;

   // waiting response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // every accepted transaction yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("response missing after request");

   // a mode write shows up in its own response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.req_type == REQ_SET_MODE
      |=> rsp_payload.mode_now == $past(req_payload.mode_value))
      else $error("mode write not reflected");

   // no response waiting means the request side is open
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

endmodule

bind status_led_pattern_engine_unit slpe_checker u_slpe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
